// ===== sv/leg_foot_trajectory_generator_macros.svh =====
// Assertion macros for the leg foot trajectory generator.
`ifndef LEG_FOOT_TRAJECTORY_GENERATOR_MACROS_SVH
`define LEG_FOOT_TRAJECTORY_GENERATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define LFT_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("implication check failed");
`define LFT_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("next cycle check failed");
`else
`define LFT_ASSERT_IMP(lbl, ant, con)
`define LFT_ASSERT_NXT(lbl, ant, con)
`endif
`endif

// ===== sv/lft_pkg.sv =====
// Shared types, constants and helpers of the leg foot trajectory generator.
package lft_pkg;

  typedef struct packed {
    logic [23:0] period;
    logic [15:0] divisions;
    logic [23:0] time_now;
    logic [22:0] swing_stride;
    logic [22:0] first_stance_stride;
    logic [15:0] heading;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] foot_x;
    logic signed [23:0] foot_y;
    logic signed [23:0] foot_z;
    logic               in_swing;
    logic               swing_done;
  } out_req_t;

  typedef struct packed {
    logic [15:0]        duty_factor;
    logic [22:0]        step_height;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [23:0] offset_z;
    logic [15:0]        mount_angle;
    logic signed [23:0] workspace_end;
  } cfg_t;

  localparam logic [2:0] REG_DUTY   = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OFS_X  = 3'd2;
  localparam logic [2:0] REG_OFS_Y  = 3'd3;
  localparam logic [2:0] REG_OFS_Z  = 3'd4;
  localparam logic [2:0] REG_MOUNT  = 3'd5;
  localparam logic [2:0] REG_WS_END = 3'd6;

  localparam logic [15:0] DUTY_RESET = 16'd49152;

  // quarter wave sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42048;
  localparam logic [16:0] SIN_C = 17'd4640;

  localparam int DIV_STEPS = 48;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BT, ST_FIRST, ST_DIVGO, ST_DIVW, ST_QUO,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_XH, ST_ZH, ST_END, ST_RX, ST_RY, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_BT, OP_FIRST, OP_DIVGO, OP_QUO,
    OP_S0, OP_S1, OP_S2, OP_S3, OP_XH, OP_ZH, OP_END, OP_RX, OP_RY, OP_OUT
  } op_t;

  typedef struct packed {
    logic       load;
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic swing;
    logic div_done;
  } sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ===== sv/lft_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module lft_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [47:0] quo,
  output logic [23:0] rem
);
  import lft_pkg::*;

  logic [47:0] quo_r, quo_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [25:0] trial;

  always_comb begin
    trial   = {1'b0, rem_r, quo_r[47]} - {2'b0, divisor};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!trial[25]) begin
        rem_nxt = trial[23:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[22:0], quo_r[47]};
        quo_nxt = {quo_r[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = (cnt_r == '0);
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// ===== sv/lft_ctrl.sv =====
// Sequencer of the trajectory generator: steps the datapath through one request.
module lft_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  lft_pkg::sts_t sts,
  output lft_pkg::cmd_t cmd
);
  import lft_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BT;
        end
      end
      ST_BT: begin
        cmd.op    = OP_BT;
        state_nxt = ST_FIRST;
      end
      ST_FIRST: begin
        cmd.op    = OP_FIRST;
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd.op    = OP_DIVGO;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) state_nxt = ST_QUO;
      end
      ST_QUO: begin
        cmd.op    = OP_QUO;
        sel_nxt   = sts.swing ? 2'd0 : 2'd2;
        state_nxt = ST_S0;
      end
      ST_S0: begin
        cmd.op    = OP_S0;
        state_nxt = ST_S1;
      end
      ST_S1: begin
        cmd.op    = OP_S1;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        cmd.op    = OP_S2;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        cmd.op = OP_S3;
        if (sel_r == 2'd3) begin
          state_nxt = sts.swing ? ST_XH : ST_RX;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = ST_S0;
        end
      end
      ST_XH: begin
        cmd.op    = OP_XH;
        state_nxt = ST_ZH;
      end
      ST_ZH: begin
        cmd.op    = OP_ZH;
        state_nxt = ST_END;
      end
      ST_END: begin
        cmd.op    = OP_END;
        state_nxt = ST_RX;
      end
      ST_RX: begin
        cmd.op    = OP_RX;
        state_nxt = ST_RY;
      end
      ST_RY: begin
        cmd.op    = OP_RY;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
endmodule

// ===== sv/lft_dpath.sv =====
// Datapath: shared multiplier, divider, sine steps and trajectory state.
module lft_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  lft_pkg::cfg_t     cfg,
  input  lft_pkg::in_req_t  in_data,
  input  lft_pkg::cmd_t     cmd,
  output lft_pkg::sts_t     sts,
  output lft_pkg::out_req_t out_data
);
  import lft_pkg::*;

  in_req_t            in_r;
  logic [23:0]        bt_r;
  logic               first_r;
  logic [22:0]        stride_r;
  logic signed [23:0] start_x_r;
  logic               swing_r, neg_r, done_r;
  logic [15:0]        ang_r;
  logic signed [23:0] x0_r, fx_r, fy_r;
  logic signed [24:0] z0_r;
  logic [16:0]        x2_r, inner_r, t_r;
  logic signed [17:0] sn_r [4];
  out_req_t           out_r;

  logic signed [25:0] ma, mb;
  logic signed [51:0] prod, rprod;
  logic signed [31:0] rnd32;
  logic signed [24:0] base, d;
  logic [23:0]        absd, den, tdiff, t, tp;
  logic [24:0]        dist1;
  logic [15:0]        divn, asum, sang, tmp16;
  logic [16:0]        sx, s17;
  logic [15:0]        xf;
  logic [21:0]        h;
  logic               is_stance;
  logic               div_start, div_done;
  logic [47:0]        dividend, quo;
  logic [23:0]        divisor, rem;

  lft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_comb begin
    t         = in_r.time_now;
    tp        = in_r.period;
    base      = 25'(cfg.offset_y) - 25'(cfg.workspace_end);
    d         = $signed({1'b0, t}) - $signed({1'b0, bt_r});
    absd      = d[24] ? 24'(-d) : d[23:0];
    den       = tp - bt_r;
    tdiff     = (t >= tp) ? (t - tp) : (tp - t);
    dist1     = {1'b0, tdiff} + 25'd1;
    divn      = (in_r.divisions == '0) ? 16'd1 : in_r.divisions;
    is_stance = (t != '0) && (t <= bt_r);
    h         = in_r.swing_stride[22:1];
    asum      = cfg.mount_angle + in_r.heading;
    case (cmd.sel)
      2'd0:    sang = ang_r + 16'd16384;
      2'd1:    sang = ang_r;
      2'd2:    sang = asum + 16'd16384;
      default: sang = asum;
    endcase
    xf = {sang[13:0], 2'b00};
    sx = sang[14] ? (17'd65536 - {1'b0, xf}) : {1'b0, xf};
  end

  // one multiplier, operands picked by the step
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_BT: begin
        ma = $signed({10'd0, cfg.duty_factor});
        mb = $signed({2'd0, tp});
      end
      OP_DIVGO: begin
        ma = $signed({3'd0, stride_r});
        mb = $signed({2'd0, t});
      end
      OP_S0: begin
        ma = $signed({9'd0, sx});
        mb = $signed({9'd0, sx});
      end
      OP_S1: begin
        ma = $signed({9'd0, SIN_C});
        mb = $signed({9'd0, x2_r});
      end
      OP_S2: begin
        ma = $signed({9'd0, x2_r});
        mb = $signed({9'd0, inner_r});
      end
      OP_S3: begin
        ma = $signed({9'd0, sx});
        mb = $signed({9'd0, t_r});
      end
      OP_XH: begin
        ma = $signed({4'd0, h});
        mb = 26'(sn_r[0]);
      end
      OP_ZH: begin
        ma = $signed({3'd0, cfg.step_height});
        mb = 26'(sn_r[1]);
      end
      OP_END: begin
        ma = $signed({1'b0, dist1});
        mb = $signed({10'd0, divn});
      end
      OP_RX: begin
        ma = 26'(x0_r);
        mb = 26'(sn_r[2]);
      end
      OP_RY: begin
        ma = 26'(x0_r);
        mb = 26'(sn_r[3]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod  = ma * mb;
    rprod = (prod + 52'sd32768) >>> 16;
    rnd32 = rprod[31:0];
    s17   = prod[32:16];
  end

  always_comb begin
    div_start = (cmd.op == OP_DIVGO);
    dividend  = swing_r ? {9'd0, absd, 15'd0} : prod[47:0];
    divisor   = swing_r ? den : bt_r;
    tmp16     = quo[15:0] + {15'd0, (rem != '0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b1;
      stride_r  <= '0;
      start_x_r <= '0;
    end else begin
      if (cmd.op == OP_FIRST && first_r) begin
        first_r   <= 1'b0;
        stride_r  <= in_r.first_stance_stride;
        start_x_r <= sat24(32'(base) - 32'($signed({1'b0, in_r.first_stance_stride})));
      end
      if (cmd.op == OP_END && (prod <= $signed({28'd0, tp}))) begin
        stride_r  <= in_r.swing_stride;
        start_x_r <= x0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    case (cmd.op)
      OP_BT: bt_r <= prod[39:16];
      OP_FIRST: begin
        swing_r <= !is_stance;
        done_r  <= 1'b0;
      end
      OP_DIVGO: neg_r <= d[24];
      OP_QUO: begin
        if (!swing_r) begin
          x0_r <= sat24(32'(start_x_r) + $signed({8'd0, quo[23:0]}));
          z0_r <= '0;
        end else if (den == '0) begin
          ang_r <= '0;
        end else begin
          ang_r <= neg_r ? (~tmp16 + 16'd1) : quo[15:0];
        end
      end
      OP_S0: x2_r    <= prod[32:16];
      OP_S1: inner_r <= SIN_B - prod[32:16];
      OP_S2: t_r     <= SIN_A - prod[32:16];
      OP_S3: sn_r[cmd.sel] <= sang[15] ? -$signed({1'b0, s17}) : $signed({1'b0, s17});
      OP_XH: x0_r <= sat24(32'(base) - $signed({10'd0, h}) + rnd32);
      OP_ZH: z0_r <= rnd32[24:0];
      OP_END: done_r <= (prod <= $signed({28'd0, tp}));
      OP_RX: fx_r <= sat24(32'(cfg.offset_x) + rnd32);
      OP_RY: fy_r <= sat24(32'(cfg.offset_y) + rnd32);
      OP_OUT: begin
        out_r.foot_x     <= fx_r;
        out_r.foot_y     <= fy_r;
        out_r.foot_z     <= sat24(32'(cfg.offset_z) + 32'(z0_r));
        out_r.in_swing   <= swing_r;
        out_r.swing_done <= done_r;
      end
      default: ;
    endcase
  end

  assign sts.swing    = swing_r;
  assign sts.div_done = div_done;
  assign out_data     = out_r;
endmodule

// ===== sv/leg_foot_trajectory_generator.sv =====
// Leg foot trajectory generator: top level with register port, sequencer and datapath.
// One request in gives one foot point out. A request runs from acceptance
// to the result register through the sequencer steps, and the next
// request can be accepted in the cycle after that: the 48-step restoring
// divider (stance interpolation, or swing angle) takes most of the run, then each
// sine or cosine takes four passes through the one shared
// 26x26 multiplier (two in stance, four in swing), followed by the rounding
// and swing-end steps in swing and the rotation steps. The input stalls while
// a request is at work; a finished point waits in the output register while
// the next request is accepted. Registers are written through the APB-style
// cfg_ port at byte address 4*index and should only change while the block is idle.
module leg_foot_trajectory_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lft_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lft_pkg::out_req_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import lft_pkg::*;
`include "leg_foot_trajectory_generator_macros.svh"

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  // register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_factor   <= DUTY_RESET;
      cfg_r.step_height   <= '0;
      cfg_r.offset_x      <= '0;
      cfg_r.offset_y      <= '0;
      cfg_r.offset_z      <= '0;
      cfg_r.mount_angle   <= '0;
      cfg_r.workspace_end <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DUTY:   cfg_r.duty_factor   <= cfg_pwdata[15:0];
        REG_HEIGHT: cfg_r.step_height   <= cfg_pwdata[22:0];
        REG_OFS_X:  cfg_r.offset_x      <= cfg_pwdata[23:0];
        REG_OFS_Y:  cfg_r.offset_y      <= cfg_pwdata[23:0];
        REG_OFS_Z:  cfg_r.offset_z      <= cfg_pwdata[23:0];
        REG_MOUNT:  cfg_r.mount_angle   <= cfg_pwdata[15:0];
        REG_WS_END: cfg_r.workspace_end <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (cfg_idx)
      REG_DUTY:   cfg_prdata = {16'd0, cfg_r.duty_factor};
      REG_HEIGHT: cfg_prdata = {9'd0, cfg_r.step_height};
      REG_OFS_X:  cfg_prdata = {8'd0, cfg_r.offset_x};
      REG_OFS_Y:  cfg_prdata = {8'd0, cfg_r.offset_y};
      REG_OFS_Z:  cfg_prdata = {8'd0, cfg_r.offset_z};
      REG_MOUNT:  cfg_prdata = {16'd0, cfg_r.mount_angle};
      REG_WS_END: cfg_prdata = {8'd0, cfg_r.workspace_end};
      default:    cfg_prdata = '0;
    endcase
  end

  lft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lft_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // an accepted request keeps the input stalled while it is worked on
  `LFT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // loading the result register always presents a point
  `LFT_ASSERT_NXT(a_out_load_valid, cmd.op == OP_OUT, out_valid)
  // swing end is only flagged in the ellipse phase
  `LFT_ASSERT_IMP(a_done_in_swing, out_valid && out_data.swing_done, out_data.in_swing)
endmodule
